// ===== src/tmp_pkg.sv =====
// ============================================================================
// Trapezoid move profile package
// Shared codes, field widths and the result record of the move generator.
// ============================================================================
package tmp_pkg;

    // Fixed field widths.
    localparam int LIM_W   = 15;           // speed_limit
    localparam int LSQ_W   = 2 * LIM_W;    // speed_limit squared
    localparam int ACC_W   = 10;           // accel_rate register
    localparam int STEP_W  = 16;           // speed_step register
    localparam int CMD_W   = 16;           // speed_cmd
    localparam int PHASE_W = 2;

    // Result stream payload: speed_cmd and phase, padded to whole bytes.
    localparam int M_DATA_W = ((CMD_W + PHASE_W + 7) / 8) * 8;

    // Command kinds carried in the input tuser bit.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Move phases.
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ACC  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CRU  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DEC  = 2'd3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ACCEL = 1'b0;
    localparam logic REG_STEP  = 1'b1;

    // Reset values of the registers.
    localparam logic [ACC_W-1:0]  ACCEL_RST = 10'd200;
    localparam logic [STEP_W-1:0] STEP_RST  = 16'd512;

    typedef struct packed {
        logic               aborted;
        logic               move_done;
        logic [PHASE_W-1:0] phase;
        logic [CMD_W-1:0]   speed_cmd;
    } tmp_result_t;

endpackage

// ===== src/trapezoid_move_profile_top.sv =====
// ============================================================================
// Trapezoid move profile generator
// Single-axis trapezoidal speed profile, stepped once per input item.
// ============================================================================
//
//  Channel   Direction  Handshake               Contents
//  --------  ---------  ----------------------  ---------------------------------
//  s_axis    in         tvalid / tready         start or tick item, one per cycle while ready
//  m_axis    out        tvalid / tready         one result item per input item
//  apb       in         psel / penable / pready accel_rate (0x0), speed_step (0x4)
//
// For every accepted item, the input fields and the profile state feed one
// level of logic (three narrow multipliers and their compares) whose outcome is
// written into the state and into the result or skid register when accepted.
// A new item is accepted in every cycle while the result side keeps up.
// When the result consumer stalls, one further item lands in a skid register;
// s_axis_tready drops only while that skid register is full.
// Reset is synchronous and active low; it clears the profile to idle and loads
// the register defaults. There is no clearing pass after reset.
//
module trapezoid_move_profile_top #(
    parameter int POS_BITS  = 24,
    parameter int FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Input items.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, from bit 0: target, abs_mode, speed_limit, measured_position,
    // move_enable, then zero fill to whole bytes.
    input  logic [((2*POS_BITS+tmp_pkg::LIM_W+2+7)/8)*8-1:0] s_axis_tdata,
    // tuser: command (0 start a move, 1 one tick).
    input  logic                      s_axis_tuser,

    // Result items.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata, from bit 0: speed_cmd, phase, then zero fill.
    output logic [tmp_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tlast: move_done.
    output logic                      m_axis_tlast,
    // tuser: aborted.
    output logic                      m_axis_tuser,

    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tmp_pkg::*;

    localparam int SP_W   = POS_BITS + 1;         // start and end positions
    localparam int D_W    = POS_BITS + 2;         // position differences
    localparam int TWOA_W = ACC_W + 2;            // 2*accel, signed
    localparam int PR_W   = D_W + TWOA_W;         // distance times 2*accel
    localparam int SPD_W  = LIM_W + FRAC_BITS + 1;
    localparam int TGT_LO = 0;
    localparam int ABS_B  = POS_BITS;
    localparam int LIM_LO = POS_BITS + 1;
    localparam int POS_LO = POS_BITS + LIM_W + 1;
    localparam int EN_B   = 2 * POS_BITS + LIM_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]  accel_reg;
    logic [STEP_W-1:0] step_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg <= ACCEL_RST;
            step_reg  <= STEP_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ACCEL: accel_reg <= pwdata[ACC_W-1:0];
                REG_STEP:  step_reg  <= pwdata[STEP_W-1:0];
                default:   accel_reg <= accel_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ACCEL: prdata = {{(32-ACC_W){1'b0}}, accel_reg};
            REG_STEP:  prdata = {{(32-STEP_W){1'b0}}, step_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Profile state
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]      phase_reg,  phase_next;
    logic [SPD_W-1:0]        speed_reg,  speed_next;
    logic signed [SP_W-1:0]  start_reg,  start_next;
    logic signed [SP_W-1:0]  end_reg,    end_next;
    logic                    down_reg,   down_next;
    logic [LIM_W-1:0]        limit_reg,  limit_next;
    logic [LSQ_W-1:0]        lsq_reg,    lsq_next;
    logic signed [CMD_W-1:0] cmd_reg,    cmd_next;

    // Input field views.
    logic                       in_start;
    logic signed [POS_BITS-1:0] in_target;
    logic                       in_abs;
    logic [LIM_W-1:0]           in_limit;
    logic signed [POS_BITS-1:0] in_pos;
    logic                       in_en;

    // Handshake.
    logic        in_acc;
    logic        out_take;
    tmp_result_t res;
    tmp_result_t out_reg;
    tmp_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    assign in_start  = (s_axis_tuser == CMD_START);
    assign in_target = s_axis_tdata[TGT_LO +: POS_BITS];
    assign in_abs    = s_axis_tdata[ABS_B];
    assign in_limit  = s_axis_tdata[LIM_LO +: LIM_W];
    assign in_pos    = s_axis_tdata[POS_LO +: POS_BITS];
    assign in_en     = s_axis_tdata[EN_B];

    assign s_axis_tready = ~skid_valid_reg;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_take      = out_valid_reg & m_axis_tready;

    // ------------------------------------------------------------------
    // One tick of the profile
    // ------------------------------------------------------------------
    // A start item first replaces the move state with the new move, then the
    // same item runs as a tick. Tests fall through accelerate, cruise and
    // decelerate in order within one tick.
    logic signed [SP_W-1:0]   pos_sp;
    logic signed [SP_W-1:0]   new_end;
    logic [PHASE_W-1:0]       e_phase;
    logic [SPD_W-1:0]         e_speed;
    logic signed [SP_W-1:0]   e_start;
    logic signed [SP_W-1:0]   e_end;
    logic                     e_down;
    logic [LIM_W-1:0]         e_limit;
    logic [LSQ_W-1:0]         e_lsq;
    logic signed [CMD_W-1:0]  e_cmd;
    logic signed [D_W-1:0]    pos_d;
    logic signed [D_W-1:0]    rem_raw;
    logic signed [D_W-1:0]    trav_raw;
    logic signed [D_W-1:0]    rem;
    logic signed [D_W-1:0]    trav;
    logic signed [D_W-1:0]    two_pos;
    logic signed [D_W-1:0]    pos_sum;
    logic signed [TWOA_W-1:0] twoa;
    logic signed [PR_W-1:0]   acc_prod;
    logic signed [PR_W-1:0]   cru_prod;
    logic signed [PR_W-1:0]   lsq_ext;
    logic                     mid_ok;
    logic                     acc_ok;
    logic                     cru_ok;
    logic                     dec_ok;
    logic [SPD_W:0]           spd_sum;
    logic [SPD_W:0]           spd_cap;
    logic [SPD_W-1:0]         spd_up;
    logic [SPD_W-1:0]         spd_down;
    logic [SPD_W-1:0]         step_ext;
    logic                     handled;
    logic                     stop;
    logic                     stop_ab;
    logic                     set_cmd;
    logic signed [CMD_W-1:0]  mag;

    always_comb begin
        pos_sp  = SP_W'(in_pos);
        new_end = in_abs ? SP_W'(in_target) : pos_sp + SP_W'(in_target);

        if (in_start) begin
            e_phase = PH_ACC;
            e_speed = '0;
            e_start = pos_sp;
            e_end   = new_end;
            e_down  = (new_end < pos_sp);
            e_limit = in_limit;
            e_lsq   = LSQ_W'(in_limit) * LSQ_W'(in_limit);
            e_cmd   = '0;
        end else begin
            e_phase = phase_reg;
            e_speed = speed_reg;
            e_start = start_reg;
            e_end   = end_reg;
            e_down  = down_reg;
            e_limit = limit_reg;
            e_lsq   = lsq_reg;
            e_cmd   = cmd_reg;
        end

        // Distances along the direction of travel.
        pos_d    = D_W'(in_pos);
        rem_raw  = D_W'(e_end) - pos_d;
        trav_raw = pos_d - D_W'(e_start);
        rem      = e_down ? -rem_raw  : rem_raw;
        trav     = e_down ? -trav_raw : trav_raw;
        two_pos  = pos_d <<< 1;
        pos_sum  = D_W'(e_start) + D_W'(e_end);
        mid_ok   = e_down ? (two_pos > pos_sum) : (two_pos < pos_sum);

        // Braking distance limit^2 / (2*accel), compared by cross-multiplying.
        twoa     = $signed({1'b0, accel_reg, 1'b0});
        acc_prod = PR_W'(trav) * PR_W'(twoa);
        cru_prod = PR_W'(rem) * PR_W'(twoa);
        lsq_ext  = $signed({{(PR_W-LSQ_W){1'b0}}, e_lsq});

        acc_ok = (acc_prod < lsq_ext) && mid_ok;
        cru_ok = (cru_prod > lsq_ext);
        dec_ok = (e_speed != '0) && (rem > 0);

        step_ext = SPD_W'(step_reg);
        spd_sum  = {1'b0, e_speed} + {1'b0, step_ext};
        spd_cap  = {2'b00, e_limit, {FRAC_BITS{1'b0}}};
        spd_up   = (spd_sum > spd_cap) ? spd_cap[SPD_W-1:0] : spd_sum[SPD_W-1:0];
        spd_down = (e_speed > step_ext) ? e_speed - step_ext : '0;

        phase_next = e_phase;
        speed_next = e_speed;
        handled    = 1'b0;
        stop       = 1'b0;
        stop_ab    = 1'b0;
        set_cmd    = 1'b0;

        if (phase_next == PH_ACC) begin
            if (acc_ok) begin
                handled = 1'b1;
                if (!in_en) begin
                    stop    = 1'b1;
                    stop_ab = 1'b1;
                end else begin
                    speed_next = spd_up;
                    set_cmd    = 1'b1;
                end
            end else begin
                phase_next = PH_CRU;
            end
        end
        if (!handled && phase_next == PH_CRU) begin
            if (cru_ok) begin
                handled = 1'b1;
                if (!in_en) begin
                    stop    = 1'b1;
                    stop_ab = 1'b1;
                end
            end else begin
                phase_next = PH_DEC;
            end
        end
        if (!handled && phase_next == PH_DEC) begin
            if (dec_ok && in_en) begin
                speed_next = spd_down;
                set_cmd    = 1'b1;
            end else begin
                // Normal end when the decelerate test fails, abort otherwise.
                stop    = 1'b1;
                stop_ab = dec_ok;
            end
        end

        mag = CMD_W'(speed_next[SPD_W-1:FRAC_BITS]);
        if (stop || phase_next == PH_IDLE) begin
            phase_next = PH_IDLE;
            speed_next = '0;
            cmd_next   = '0;
        end else if (set_cmd) begin
            cmd_next = e_down ? -mag : mag;
        end else begin
            cmd_next = e_cmd;
        end

        start_next = e_start;
        end_next   = e_end;
        down_next  = e_down;
        limit_next = e_limit;
        lsq_next   = e_lsq;

        res.speed_cmd = cmd_next;
        res.phase     = phase_next;
        res.move_done = stop;
        res.aborted   = stop_ab;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            speed_reg <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            down_reg  <= 1'b0;
            limit_reg <= '0;
            lsq_reg   <= '0;
            cmd_reg   <= '0;
        end else if (in_acc) begin
            phase_reg <= phase_next;
            speed_reg <= speed_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            down_reg  <= down_next;
            limit_reg <= limit_next;
            lsq_reg   <= lsq_next;
            cmd_reg   <= cmd_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register with one skid entry
    // ------------------------------------------------------------------
    // The skid entry fills only while the result register is held, so the
    // input side can take one further item past a stall.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_acc;
            end
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_take) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (in_acc && out_valid_reg && !out_take) begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W-CMD_W-PHASE_W){1'b0}}, out_reg.phase,
                            out_reg.speed_cmd};
    assign m_axis_tlast  = out_reg.move_done;
    assign m_axis_tuser  = out_reg.aborted;

endmodule

// ===== src/tmp_check.sv =====
// ============================================================================
// Trapezoid move profile port checker
// Watches the result stream of the move generator and flags bad sequences.
// ============================================================================
module tmp_check (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [tmp_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic                         m_axis_tuser
);
    import tmp_pkg::*;

    logic [CMD_W-1:0]   speed;
    logic [PHASE_W-1:0] phase;

    assign speed = m_axis_tdata[CMD_W-1:0];
    assign phase = m_axis_tdata[CMD_W +: PHASE_W];

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An abort always ends the move.
    a_abort_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("abort without move end");

    // A finished move leaves the axis idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> phase == PH_IDLE)
        else $error("move ended but phase not idle");

    // An idle axis is commanded to stand still.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && phase == PH_IDLE |-> speed == '0)
        else $error("idle axis with nonzero speed");

endmodule

bind trapezoid_move_profile_top tmp_check u_tmp_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_trapezoid_move_profile_top.sv =====
// ============================================================================
// Testbench for the trapezoid move profile generator
// Sends start and tick items to the block, computes the expected speed
// command, phase and end flags for each item it accepts, and compares them
// field by field with the result stream. The run first sends directed moves,
// then random moves, while the acceleration and step registers are changed
// between stretches of traffic.
// ============================================================================
module tb_trapezoid_move_profile_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int LIM_W    = tmp_pkg::LIM_W;
    localparam int CMD_W    = tmp_pkg::CMD_W;
    localparam int S_DATA_W = ((2 * POS_W + tmp_pkg::LIM_W + 2 + 7) / 8) * 8;
    localparam int S_FILL_W = S_DATA_W - (2 * POS_W + tmp_pkg::LIM_W + 2);

    // Cycles in which neither stream nor the register port moves anything
    // before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Length of the one long stall of the result consumer.
    localparam int HOLD_CYCLES    = 80;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int DRAIN_CYCLES   = 8;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'h7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'h800000;
    localparam logic [tmp_pkg::LIM_W-1:0] LIM_MAX = 15'h7FFF;

    // One input item as the stimulus sees it, before packing onto the bus.
    typedef struct {
        logic                     command;
        logic signed [POS_W-1:0]  target;
        logic                     abs_mode;
        logic [tmp_pkg::LIM_W-1:0] speed_limit;
        logic signed [POS_W-1:0]  position;
        logic                     enable;
    } move_item_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          s_axis_tvalid  = 1'b0;
    logic                          s_axis_tready;
    logic [S_DATA_W-1:0]           s_axis_tdata   = '0;
    logic                          s_axis_tuser   = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready  = 1'b0;
    logic [tmp_pkg::M_DATA_W-1:0]  m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [2:0]                    paddr          = '0;
    logic [31:0]                   pwdata         = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // ------------------------------------------------------------------------
    // Testbench state.
    // ------------------------------------------------------------------------
    move_item_t            move_items_q[$];        // items waiting to be sent
    tmp_pkg::tmp_result_t  expected_profile_q[$];  // results still owed
    move_item_t            item_on_bus;
    int                    mismatch_count = 0;
    int                    quiet_cycles   = 0;
    int                    send_idle_pct  = 0;
    int                    recv_idle_pct  = 0;
    logic                  hold_kick      = 1'b0;
    logic                  hold_seen      = 1'b0;
    int                    hold_left      = 0;

    // Profile state of the predictor, mirroring what the block keeps.
    logic [tmp_pkg::ACC_W-1:0]   pr_accel = tmp_pkg::ACCEL_RST;
    logic [tmp_pkg::STEP_W-1:0]  pr_step  = tmp_pkg::STEP_RST;
    logic [tmp_pkg::PHASE_W-1:0] pr_phase = tmp_pkg::PH_IDLE;
    longint                      pr_speed = 0;   // Q8 speed magnitude
    longint                      pr_start = 0;
    longint                      pr_end   = 0;
    logic                        pr_down  = 1'b0;
    longint                      pr_limit = 0;
    longint                      pr_lsq   = 0;
    logic [tmp_pkg::CMD_W-1:0]   pr_cmd   = '0;

    trapezoid_move_profile_top #(
        .POS_BITS  (POS_W),
        .FRAC_BITS (FRAC_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor: advances the profile by one accepted item and returns the
    // result that the block owes for it. A start item first loads the move
    // and is then treated as a tick. Within a tick the accelerate, cruise and
    // decelerate tests run in that order. A failing accelerate or cruise test
    // hands over to the next phase in the same tick; a failing decelerate test
    // ends the move. The enable input only matters in a phase whose test holds.
    // ------------------------------------------------------------------------
    function automatic tmp_pkg::tmp_result_t advance_profile(input move_item_t it);
        tmp_pkg::tmp_result_t r;
        longint p, dir, twoa, rem, trav, cap;
        logic   ended, by_abort, test_held;
        p        = longint'(it.position);
        ended    = 1'b0;
        by_abort = 1'b0;
        if (it.command == tmp_pkg::CMD_START) begin
            pr_start = p;
            pr_end   = it.abs_mode ? longint'(it.target) : p + longint'(it.target);
            pr_down  = (pr_end < pr_start);
            pr_limit = longint'(it.speed_limit);
            pr_lsq   = pr_limit * pr_limit;
            pr_speed = 0;
            pr_cmd   = '0;
            pr_phase = tmp_pkg::PH_ACC;
        end
        if (pr_phase == tmp_pkg::PH_IDLE) begin
            pr_cmd = '0;
        end else begin
            dir       = pr_down ? -1 : 1;
            twoa      = 2 * longint'(pr_accel);
            rem       = (pr_end - p) * dir;
            test_held = 1'b0;
            if (pr_phase == tmp_pkg::PH_ACC) begin
                trav = (p - pr_start) * dir;
                // Keep accelerating while short of both the braking distance
                // and the midpoint of the move.
                if (twoa * trav < pr_lsq && 2 * p * dir < (pr_start + pr_end) * dir) begin
                    test_held = 1'b1;
                    if (!it.enable) begin
                        ended    = 1'b1;
                        by_abort = 1'b1;
                    end else begin
                        cap      = pr_limit << FRAC_W;
                        pr_speed = pr_speed + longint'(pr_step);
                        if (pr_speed > cap) begin
                            pr_speed = cap;
                        end
                        pr_cmd = CMD_W'((pr_speed >>> FRAC_W) * dir);
                    end
                end else begin
                    pr_phase = tmp_pkg::PH_CRU;
                end
            end
            if (!test_held && pr_phase == tmp_pkg::PH_CRU) begin
                if (rem * twoa > pr_lsq) begin
                    test_held = 1'b1;
                    if (!it.enable) begin
                        ended    = 1'b1;
                        by_abort = 1'b1;
                    end
                end else begin
                    pr_phase = tmp_pkg::PH_DEC;
                end
            end
            if (!test_held && pr_phase == tmp_pkg::PH_DEC) begin
                if (pr_speed > 0 && rem > 0) begin
                    if (!it.enable) begin
                        ended    = 1'b1;
                        by_abort = 1'b1;
                    end else begin
                        // The speed clamps at zero instead of going negative.
                        pr_speed = (pr_speed > longint'(pr_step)) ?
                                   pr_speed - longint'(pr_step) : 0;
                        pr_cmd   = CMD_W'((pr_speed >>> FRAC_W) * dir);
                    end
                end else begin
                    ended = 1'b1;
                end
            end
            if (ended) begin
                pr_phase = tmp_pkg::PH_IDLE;
                pr_speed = 0;
                pr_cmd   = '0;
            end
        end
        r.speed_cmd = pr_cmd;
        r.phase     = pr_phase;
        r.move_done = ended;
        r.aborted   = by_abort;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_item(input logic command, input logic [POS_W-1:0] target,
                                       input logic abs_mode,
                                       input logic [tmp_pkg::LIM_W-1:0] speed_limit,
                                       input logic [POS_W-1:0] position, input logic enable);
        move_items_q.push_back('{command, target, abs_mode, speed_limit, position, enable});
    endfunction

    // A start followed by a run of ticks whose position walks toward the end
    // of the move, sometimes stalling and often overshooting, so that moves
    // pass through acceleration, cruise and braking. Enable drops now and then.
    task automatic queue_move(ref int queued);
        int                        span, stride, ticks;
        logic signed [POS_W-1:0]   pos, goal;
        logic                      up, absm;
        logic [tmp_pkg::LIM_W-1:0] lim;
        span = ($urandom_range(9) == 0) ? $urandom_range(60000) : $urandom_range(3000);
        up   = 1'($urandom_range(1));
        absm = 1'($urandom_range(1));
        pos  = ($urandom_range(7) == 0) ? POS_W'($urandom) :
                                          POS_W'($urandom_range(20000) - 10000);
        case ($urandom_range(9))
            0:       lim = '0;
            1:       lim = LIM_MAX;
            2:       lim = LIM_W'($urandom);
            default: lim = LIM_W'($urandom_range(400, 1));
        endcase
        goal = up ? POS_W'(pos + span) : POS_W'(pos - span);
        queue_item(tmp_pkg::CMD_START, absm ? goal : POS_W'(up ? span : -span), absm, lim,
                   pos, $urandom_range(29) != 0);
        ticks  = $urandom_range(40, 4);
        stride = span / 12 + 1;
        repeat (ticks) begin
            pos = up ? POS_W'(pos + $urandom_range(stride)) :
                       POS_W'(pos - $urandom_range(stride));
            queue_item(tmp_pkg::CMD_TICK, POS_W'($urandom), 1'($urandom_range(1)),
                       LIM_W'($urandom), pos, $urandom_range(29) != 0);
        end
        queued += ticks + 1;
    endtask

    // Mostly well-formed moves; about one choice in ten is instead a single item
    // drawn at random over the full range of every field.
    task automatic queue_random_phase(input int count);
        int queued;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(9) == 0) begin
                queue_item(1'($urandom_range(1)), POS_W'($urandom), 1'($urandom_range(1)),
                           LIM_W'($urandom), POS_W'($urandom), 1'($urandom_range(1)));
                queued++;
            end else begin
                queue_move(queued);
            end
        end
    endtask

    // Waits until every queued item is sent and every result has come back.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (move_items_q.size() != 0 || s_axis_tvalid || expected_profile_q.size() != 0);
    endtask

    // Writes one register through the configuration port, reads it back and
    // updates the predictor's copy. Only called while the block is idle.
    task automatic write_reg(input logic regsel, input logic [31:0] value);
        logic [31:0] readback;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        // The write has landed; turn straight into the setup of a read.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (regsel == tmp_pkg::REG_ACCEL) begin
            pr_accel = value[tmp_pkg::ACC_W-1:0];
        end else begin
            pr_step = value[tmp_pkg::STEP_W-1:0];
        end
        if (readback !== value) begin
            $error("prdata: expected 0x%08h, got 0x%08h", value, readback);
            mismatch_count++;
        end
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver. When the bus is free it offers the next pending item, unless it
    // decides to idle this cycle. The prediction is made at the edge where the
    // block accepts the item, so the expected results stay in item order.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_profile_q.push_back(advance_profile(item_on_bus));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (move_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_bus = move_items_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{S_FILL_W{1'b0}}, item_on_bus.enable,
                                      item_on_bus.position, item_on_bus.speed_limit,
                                      item_on_bus.abs_mode, item_on_bus.target};
                    s_axis_tuser  <= item_on_bus.command;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result consumer. A toggle of hold_kick starts one long stall, counted
    // here, during which the driver keeps offering items so that the block
    // fills up and drops s_axis_tready. Otherwise ready is drawn at random.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_kick) begin
            hold_seen     <= hold_kick;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every accepted result is checked against the oldest expected
    // one, field by field.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        tmp_pkg::tmp_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_profile_q.size() == 0) begin
                $error("result item with nothing expected: speed_cmd %0d, phase %0d",
                       $signed(m_axis_tdata[15:0]), m_axis_tdata[17:16]);
                mismatch_count++;
            end else begin
                want = expected_profile_q.pop_front();
                if (m_axis_tdata[15:0] !== want.speed_cmd) begin
                    $error("speed_cmd: expected %0d, got %0d",
                           $signed(want.speed_cmd), $signed(m_axis_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[17:16] !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, m_axis_tdata[17:16]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.move_done) begin
                    $error("move_done: expected %0b, got %0b", want.move_done, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.aborted) begin
                    $error("aborted: expected %0b, got %0b", want.aborted, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Counts cycles in which nothing moves on either stream or the
    // register port; a hung block ends the run as a failure.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_trapezoid_move_profile_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. Queues and settings change at the falling edge; port and reset
    // changes are nonblocking, so clocked processes see a well-defined edge.
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed moves with the reset register values. The sender idles
        // lightly and the consumer heavily.
        send_idle_pct = 23;
        recv_idle_pct = 66;
        // Ticks while idle, with extreme field values and enable both ways.
        queue_item(tmp_pkg::CMD_TICK, POS_MAX, 1'b1, LIM_MAX, POS_MIN, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, POS_MIN, 1'b0, '0, POS_MAX, 1'b0);
        // A move of zero length is done on its own start item.
        queue_item(tmp_pkg::CMD_START, 24'sd0, 1'b0, 15'd100, 24'sd1000, 1'b1);
        // Absolute move across the whole range at the highest speed limit.
        queue_item(tmp_pkg::CMD_START, POS_MAX, 1'b1, LIM_MAX, POS_MIN, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, POS_MIN + 24'sd5000, 1'b1);
        // A new start drops the running move. Relative and downward from the
        // bottom of the range, so the end lies beyond the position width. A
        // zero limit goes straight to cruise, where enable low aborts.
        queue_item(tmp_pkg::CMD_START, POS_MIN, 1'b0, '0, POS_MIN, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, POS_MIN, 1'b0);
        // Relative and upward from the top of the range.
        queue_item(tmp_pkg::CMD_START, POS_MAX, 1'b0, 15'd50, POS_MAX, 1'b1);
        // Enable low on the start item aborts during acceleration.
        queue_item(tmp_pkg::CMD_START, 24'sd300, 1'b0, 15'd20, 24'sd0, 1'b0);
        // A complete upward move: accelerate, cruise, brake to
        // zero speed and finish at the end position.
        queue_item(tmp_pkg::CMD_START, 24'sd100, 1'b1, 15'd40, 24'sd0, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd2, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd5, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd97, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd99, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd100, 1'b1);
        // A relative downward move that is aborted while braking.
        queue_item(tmp_pkg::CMD_START, -24'sd100, 1'b0, 15'd40, 24'sd500, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd498, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd495, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd403, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd402, 1'b0);
        // Overshooting the end ends the move as soon as braking is tested.
        queue_item(tmp_pkg::CMD_START, 24'sd1000, 1'b1, 15'd40, 24'sd0, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd3, 1'b1);
        queue_item(tmp_pkg::CMD_TICK, '0, 1'b0, '0, 24'sd1200, 1'b1);
        wait_drained();

        // Slowest settings: smallest acceleration and smallest speed step.
        write_reg(tmp_pkg::REG_ACCEL, 32'd1);
        write_reg(tmp_pkg::REG_STEP, 32'd1);
        queue_random_phase(115);
        wait_drained();

        // Largest settings, and the one long stall of the consumer at the
        // start of this stretch while the sender keeps offering items.
        write_reg(tmp_pkg::REG_ACCEL, 32'd1023);
        write_reg(tmp_pkg::REG_STEP, 32'd65535);
        hold_kick = ~hold_kick;
        queue_random_phase(115);
        wait_drained();

        // From here the sender idles heavily and the consumer lightly. Zero
        // register values are out of the normal range but still defined.
        send_idle_pct = 66;
        recv_idle_pct = 23;
        write_reg(tmp_pkg::REG_ACCEL, 32'd0);
        write_reg(tmp_pkg::REG_STEP, 32'd0);
        queue_random_phase(115);
        wait_drained();

        write_reg(tmp_pkg::REG_ACCEL, $urandom_range(1023, 1));
        write_reg(tmp_pkg::REG_STEP, $urandom_range(65535, 1));
        queue_random_phase(115);
        wait_drained();

        // Back to the reset values, with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(tmp_pkg::REG_ACCEL, 32'd200);
        write_reg(tmp_pkg::REG_STEP, 32'd512);
        queue_random_phase(115);
        wait_drained();

        // Give any stray result a chance to appear before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_trapezoid_move_profile_top: clean");
        end else begin
            $display("tb_trapezoid_move_profile_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tmp_pkg.sv
src/trapezoid_move_profile_top.sv
src/tmp_check.sv
verif/tb_trapezoid_move_profile_top.sv
